/* rtl/core/i2a_pkg.sv */
// Shared types, format codes and digit tables for the integer to ASCII unit.
`timescale 1ns / 1ps
package i2a_pkg;

  // Format codes carried on in_command
  localparam logic [1:0] CMD_SDEC = 2'd0;
  localparam logic [1:0] CMD_UDEC = 2'd1;
  localparam logic [1:0] CMD_HEXL = 2'd2;
  localparam logic [1:0] CMD_HEXU = 2'd3;

  localparam int I2A_QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  // One classified item: sign already stripped off
  typedef struct packed {
    logic        neg;
    logic [31:0] mag;
    logic        hex;
    logic        upper;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_EMIT
  } back_state_t;

  // k * 10^pos, wide enough for 9 * 10^9
  function automatic logic [33:0] dec_weight(input logic [3:0] k, input logic [3:0] pos);
    logic [33:0] base;
    case (pos)
      4'd0:    base = 34'd1;
      4'd1:    base = 34'd10;
      4'd2:    base = 34'd100;
      4'd3:    base = 34'd1000;
      4'd4:    base = 34'd10000;
      4'd5:    base = 34'd100000;
      4'd6:    base = 34'd1000000;
      4'd7:    base = 34'd10000000;
      4'd8:    base = 34'd100000000;
      4'd9:    base = 34'd1000000000;
      default: base = 34'd0;
    endcase
    return 34'(base * {30'd0, k});
  endfunction

  // Hex digit to ASCII, either case
  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CHAR_ZERO + {4'd0, nib};
    end else if (upper) begin
      c = 8'h41 + {4'd0, nib - 4'd10};
    end else begin
      c = 8'h61 + {4'd0, nib - 4'd10};
    end
    return c;
  endfunction

endpackage

/* rtl/core/i2a_front.sv */
// Front end: classifies an incoming word into sign, magnitude and radix.
`timescale 1ns / 1ps
module i2a_front (
  input  logic [31:0]        value,
  input  logic [1:0]         command,
  output i2a_pkg::item_t     item
);
  import i2a_pkg::*;

  // Only signed decimal looks at the top bit; the most negative value
  // negates to 2^31, which fits the unsigned magnitude.
  always_comb begin
    item.neg   = (command == CMD_SDEC) && value[31];
    item.mag   = item.neg ? (32'd0 - value) : value;
    item.hex   = (command == CMD_HEXL) || (command == CMD_HEXU);
    item.upper = (command == CMD_HEXU);
  end

endmodule

/* rtl/core/i2a_queue.sv */
// Short item queue between the front end and the digit emitter.
`timescale 1ns / 1ps
module i2a_queue #(
  parameter int DEPTH = i2a_pkg::I2A_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  i2a_pkg::item_t  push_item,
  output logic            full,
  input  logic            pop,
  output i2a_pkg::item_t  pop_item,
  output logic            not_empty
);
  import i2a_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/i2a_back.sv */
// Back end: sizes the number, then emits its characters one per cycle while out_ready allows.
`timescale 1ns / 1ps
module i2a_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  i2a_pkg::item_t  q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_ascii_char,
  output logic            out_last_char,
  output logic [3:0]      out_total_chars
);
  import i2a_pkg::*;

  back_state_t  state_r, state_nxt;
  item_t        work_r, work_nxt;
  logic [3:0]   pos_r, pos_nxt;
  logic [3:0]   cnt_r, cnt_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [7:0]   out_char_r, out_char_nxt;
  logic         out_last_r, out_last_nxt;
  logic [3:0]   out_total_r, out_total_nxt;

  logic         out_free;
  logic [3:0]   ndig;
  logic [3:0]   dig;
  logic [33:0]  dig_weight;
  logic [3:0]   nib;
  logic         is_last;

  assign out_free        = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_ascii_char  = out_char_r;
  assign out_last_char   = out_last_r;
  assign out_total_chars = out_total_r;

  // Digit count of the magnitude (at least one)
  always_comb begin
    ndig = 4'd1;
    if (work_r.hex) begin
      for (int i = 1; i < 8; i++) begin
        if (work_r.mag[4*i +: 4] != 4'd0) begin
          ndig = 4'(i + 1);
        end
      end
    end else begin
      for (int i = 1; i < 10; i++) begin
        if ({2'b00, work_r.mag} >= dec_weight(4'd1, 4'(i))) begin
          ndig = 4'(i + 1);
        end
      end
    end
  end

  // Leading decimal digit: largest k with k * 10^pos <= mag
  always_comb begin
    dig        = 4'd0;
    dig_weight = 34'd0;
    for (int k = 1; k < 10; k++) begin
      if ({2'b00, work_r.mag} >= dec_weight(4'(k), pos_r)) begin
        dig        = 4'(k);
        dig_weight = dec_weight(4'(k), pos_r);
      end
    end
  end

  assign nib     = work_r.mag[{pos_r[2:0], 2'b00} +: 4];
  assign is_last = !work_r.neg && (pos_r == 4'd0);

  // Sequencer and output slot
  always_comb begin
    state_nxt     = state_r;
    work_nxt      = work_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_total_nxt = out_total_r;
    q_pop         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          work_nxt  = q_item;
          cnt_nxt   = 4'd0;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        pos_nxt   = ndig - 4'd1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          cnt_nxt       = cnt_r + 4'd1;
          out_last_nxt  = is_last;
          out_total_nxt = is_last ? cnt_r + 4'd1 : 4'd0;
          if (work_r.neg) begin
            out_char_nxt = CHAR_MINUS;
            work_nxt.neg = 1'b0;
          end else begin
            if (work_r.hex) begin
              out_char_nxt = hex_char(nib, work_r.upper);
            end else begin
              out_char_nxt = CHAR_ZERO + {4'd0, dig};
              work_nxt.mag = work_r.mag - dig_weight[31:0];
            end
            pos_nxt = pos_r - 4'd1;
            if (is_last) begin
              // Start the next number straight away when one is waiting
              if (q_valid) begin
                q_pop     = 1'b1;
                work_nxt  = q_item;
                cnt_nxt   = 4'd0;
                state_nxt = ST_SETUP;
              end else begin
                state_nxt = ST_IDLE;
              end
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and output payload
  always_ff @(posedge clk) begin
    work_r      <= work_nxt;
    pos_r       <= pos_nxt;
    cnt_r       <= cnt_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_total_r <= out_total_nxt;
  end

endmodule

/* rtl/core/integer_to_ascii_digits_unit.sv */
// Top level of the integer to ASCII digit unit.
//
// Input channel (in_valid/in_ready): a 32-bit in_value and a 2-bit in_command
// (signed decimal, unsigned decimal, lowercase hex, uppercase hex).
// Output channel (out_valid/out_ready): one ASCII character per item, most
// significant first, a leading '-' for negative signed values. The final
// character has out_last_char set and out_total_chars holding the count.
// Items pass through a short queue into the emitter, so new words are taken
// while characters of an earlier word still drain.
// The first character of a word passes the queue, the sizing step and the
// output register in that order when the emitter is free.
// Characters leave one per cycle while out_ready is high, plus a sizing step per word.
// The decimal sizing and digit steps use a bank of constant compares against
// powers of ten; the output register sets the one-character-per-cycle pace.
// Reset empties the queue and the output register. When out_ready is low the
// current character holds, the emitter stops, and in_ready drops once the
// queue fills.
`timescale 1ns / 1ps
module integer_to_ascii_digits_unit #(
  parameter int QUEUE_DEPTH = i2a_pkg::I2A_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_value,
  input  logic [1:0]  in_command,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_ascii_char,
  output logic        out_last_char,
  output logic [3:0]  out_total_chars
);
  import i2a_pkg::*;

  item_t  front_item;
  item_t  q_item;
  logic   q_full;
  logic   q_valid;
  logic   q_pop;
  logic   push;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  i2a_front u_front (
    .value   (in_value),
    .command (in_command),
    .item    (front_item)
  );

  i2a_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .not_empty (q_valid)
  );

  i2a_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ascii_char  (out_ascii_char),
    .out_last_char   (out_last_char),
    .out_total_chars (out_total_chars)
  );

endmodule
